/* rtl/core/mfl_pkg.sv */
// ----------------------------------------------------------------------------
// mfl_pkg
// shared codes and control/status types for the free rectangle list block
// ----------------------------------------------------------------------------
`default_nettype none

package mfl_pkg;

  // reset size of the root rectangle, before truncation to the coordinate width
  localparam int ROOT_SIZE_RESET = 1024;

  typedef enum logic [1:0] {
    ACT_PLACE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    REG_ROOT_X      = 2'd0,
    REG_ROOT_Y      = 2'd1,
    REG_ROOT_WIDTH  = 2'd2,
    REG_ROOT_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_SPL_CHK,
    ST_SPL_LD,
    ST_SPL_EV,
    ST_APP_CHK,
    ST_APP_WR,
    ST_PR_CHK,
    ST_PR_LDI,
    ST_PR_SCAN,
    ST_CP_CHK,
    ST_CP_WR,
    ST_RD_WAIT,
    ST_FIN
  } ctrl_state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_INIT,
    OP_ACCEPT,
    OP_SPL_RD,
    OP_SPL_END,
    OP_SPL_LD,
    OP_SPL_KEEP,
    OP_SPL_PIECE,
    OP_APP_RD,
    OP_APP_END,
    OP_APP_WR,
    OP_PR_RDI,
    OP_PR_END,
    OP_PR_LDI,
    OP_PR_SCAN,
    OP_PR_MARK,
    OP_CP_RD,
    OP_CP_END,
    OP_CP_WR,
    OP_RD_RD,
    OP_RD_CAP,
    OP_CLR,
    OP_FIN_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic       i_ge_cnt;    // walk index reached the list count
    logic       i_ge_np;     // walk index reached the piece count
    logic       overlap;     // current entry overlaps the used rectangle
    logic       last_piece;  // piece step is on the right piece
    logic       scan_done;   // containment scan for one entry finished
    logic       out_free;    // result register can take a new beat
    logic [1:0] act;         // action of the item in work
  } dp_status_t;

endpackage

`default_nettype wire

/* rtl/core/mfl_in_if.sv */
// ----------------------------------------------------------------------------
// mfl_in_if
// request channel: action, used rectangle and read index
// ----------------------------------------------------------------------------
`default_nettype none

interface mfl_in_if #(
  parameter int COORD_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            action;
  logic [COORD_BITS-1:0] used_x;
  logic [COORD_BITS-1:0] used_y;
  logic [COORD_BITS-1:0] used_width;
  logic [COORD_BITS-1:0] used_height;
  logic [5:0]            read_index;

  modport source (
    output valid, action, used_x, used_y, used_width, used_height, read_index,
    input  ready
  );
  modport sink (
    input  valid, action, used_x, used_y, used_width, used_height, read_index,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/mfl_out_if.sv */
// ----------------------------------------------------------------------------
// mfl_out_if
// response channel: entry read, free count and overflow flag
// ----------------------------------------------------------------------------
`default_nettype none

interface mfl_out_if #(
  parameter int COORD_BITS = 16,
  parameter int COUNT_BITS = 7
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] entry_x;
  logic [COORD_BITS-1:0] entry_y;
  logic [COORD_BITS-1:0] entry_width;
  logic [COORD_BITS-1:0] entry_height;
  logic                  entry_valid;
  logic [COUNT_BITS-1:0] free_count;
  logic                  overflow;

  modport source (
    output valid, entry_x, entry_y, entry_width, entry_height, entry_valid,
           free_count, overflow,
    input  ready
  );
  modport sink (
    input  valid, entry_x, entry_y, entry_width, entry_height, entry_valid,
           free_count, overflow,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/maxrects_free_list_update.sv */
// ----------------------------------------------------------------------------
// maxrects_free_list_update
// free rectangle list for 2d bin packing: split, prune and compact on place
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake      beat contents
//  -------  ---  -------------  ----------------------------------------------
//  req      in   valid/ready    action, used_x/y/width/height, read_index
//  rsp      out  valid/ready    entry_x/y/width/height, entry_valid,
//                               free_count, overflow
//  cfg      in   cfg_we only    cfg_index, cfg_data (root rectangle registers)
//
//  a place walks the list of n entries and its p new pieces; its time is set
//  by the list memory (one read port, one write port) walked by the prune
//  scan (one pair compared per cycle).
//  after reset the init state writes the root into entry 0 before req.ready rises.
//  a finished beat waits in the rsp register while the next req beat is taken.
//
`default_nettype none

module maxrects_free_list_update #(
  parameter  int MAX_FREE   = 64,
  parameter  int COORD_BITS = 16,
  localparam int CW         = $clog2(MAX_FREE + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  mfl_in_if.sink                     req,
  mfl_out_if.source                  rsp,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [COORD_BITS-1:0] cfg_data
);

  mfl_pkg::dp_cmd_t    cmd;
  mfl_pkg::dp_status_t sts;

  // sequencer: one state per memory access of each phase
  mfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // list memory, piece buffer, counters and result register
  mfl_dp #(
    .MAX_FREE   (MAX_FREE),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .action       (req.action),
    .used_x       (req.used_x),
    .used_y       (req.used_y),
    .used_width   (req.used_width),
    .used_height  (req.used_height),
    .read_index   (req.read_index),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rsp_ready    (rsp.ready),
    .rsp_valid    (rsp.valid),
    .entry_x      (rsp.entry_x),
    .entry_y      (rsp.entry_y),
    .entry_width  (rsp.entry_width),
    .entry_height (rsp.entry_height),
    .entry_valid  (rsp.entry_valid),
    .free_count   (rsp.free_count),
    .overflow     (rsp.overflow)
  );

`ifndef SYNTHESIS
  // the list never reports more entries than it can hold
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.free_count <= CW'(MAX_FREE)))
    else $error("free_count beyond capacity");

  // an entry that is not valid carries zero fields
  a_invalid_zero : assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.entry_valid) |->
      (rsp.entry_x == '0 && rsp.entry_y == '0 &&
       rsp.entry_width == '0 && rsp.entry_height == '0))
    else $error("invalid entry with nonzero fields");

  // one beat in work at a time: ready drops after an accepted beat
  a_one_in_work : assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("req accepted while a beat is in work");
`endif

endmodule

`default_nettype wire

/* rtl/core/mfl_ctrl.sv */
// ----------------------------------------------------------------------------
// mfl_ctrl
// sequencer: walks split, append, prune and compact phases of a place item
// and steps read and clear items through to the response register
`default_nettype none

module mfl_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire mfl_pkg::dp_status_t sts,
  output mfl_pkg::dp_cmd_t         cmd
);

  mfl_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mfl_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = mfl_pkg::OP_NONE;
    req_ready  = 1'b0;
    unique case (state)
      mfl_pkg::ST_INIT: begin
        cmd.op     = mfl_pkg::OP_INIT;
        state_next = mfl_pkg::ST_IDLE;
      end
      mfl_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.op     = mfl_pkg::OP_ACCEPT;
          state_next = mfl_pkg::ST_DISPATCH;
        end
      end
      mfl_pkg::ST_DISPATCH: begin
        unique case (sts.act)
          mfl_pkg::ACT_PLACE: state_next = mfl_pkg::ST_SPL_CHK;
          mfl_pkg::ACT_READ: begin
            cmd.op     = mfl_pkg::OP_RD_RD;
            state_next = mfl_pkg::ST_RD_WAIT;
          end
          mfl_pkg::ACT_CLEAR: begin
            cmd.op     = mfl_pkg::OP_CLR;
            state_next = mfl_pkg::ST_FIN;
          end
          default: state_next = mfl_pkg::ST_FIN;
        endcase
      end
      mfl_pkg::ST_SPL_CHK: begin
        if (sts.i_ge_cnt) begin
          cmd.op     = mfl_pkg::OP_SPL_END;
          state_next = mfl_pkg::ST_APP_CHK;
        end else begin
          cmd.op     = mfl_pkg::OP_SPL_RD;
          state_next = mfl_pkg::ST_SPL_LD;
        end
      end
      mfl_pkg::ST_SPL_LD: begin
        cmd.op     = mfl_pkg::OP_SPL_LD;
        state_next = mfl_pkg::ST_SPL_EV;
      end
      mfl_pkg::ST_SPL_EV: begin
        if (!sts.overlap) begin
          cmd.op     = mfl_pkg::OP_SPL_KEEP;
          state_next = mfl_pkg::ST_SPL_CHK;
        end else begin
          cmd.op = mfl_pkg::OP_SPL_PIECE;
          if (sts.last_piece) state_next = mfl_pkg::ST_SPL_CHK;
        end
      end
      mfl_pkg::ST_APP_CHK: begin
        if (sts.i_ge_np) begin
          cmd.op     = mfl_pkg::OP_APP_END;
          state_next = mfl_pkg::ST_PR_CHK;
        end else begin
          cmd.op     = mfl_pkg::OP_APP_RD;
          state_next = mfl_pkg::ST_APP_WR;
        end
      end
      mfl_pkg::ST_APP_WR: begin
        cmd.op     = mfl_pkg::OP_APP_WR;
        state_next = mfl_pkg::ST_APP_CHK;
      end
      mfl_pkg::ST_PR_CHK: begin
        if (sts.i_ge_cnt) begin
          cmd.op     = mfl_pkg::OP_PR_END;
          state_next = mfl_pkg::ST_CP_CHK;
        end else begin
          cmd.op     = mfl_pkg::OP_PR_RDI;
          state_next = mfl_pkg::ST_PR_LDI;
        end
      end
      mfl_pkg::ST_PR_LDI: begin
        cmd.op     = mfl_pkg::OP_PR_LDI;
        state_next = mfl_pkg::ST_PR_SCAN;
      end
      mfl_pkg::ST_PR_SCAN: begin
        if (sts.scan_done) begin
          cmd.op     = mfl_pkg::OP_PR_MARK;
          state_next = mfl_pkg::ST_PR_CHK;
        end else begin
          cmd.op = mfl_pkg::OP_PR_SCAN;
        end
      end
      mfl_pkg::ST_CP_CHK: begin
        if (sts.i_ge_cnt) begin
          cmd.op     = mfl_pkg::OP_CP_END;
          state_next = mfl_pkg::ST_FIN;
        end else begin
          cmd.op     = mfl_pkg::OP_CP_RD;
          state_next = mfl_pkg::ST_CP_WR;
        end
      end
      mfl_pkg::ST_CP_WR: begin
        cmd.op     = mfl_pkg::OP_CP_WR;
        state_next = mfl_pkg::ST_CP_CHK;
      end
      mfl_pkg::ST_RD_WAIT: begin
        cmd.op     = mfl_pkg::OP_RD_CAP;
        state_next = mfl_pkg::ST_FIN;
      end
      mfl_pkg::ST_FIN: begin
        if (sts.out_free) begin
          cmd.op     = mfl_pkg::OP_FIN_OUT;
          state_next = mfl_pkg::ST_IDLE;
        end
      end
      default: state_next = mfl_pkg::ST_INIT;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/mfl_dp.sv */
// ----------------------------------------------------------------------------
// mfl_dp
// datapath: list and piece memories, walk counters, split and containment logic
// ----------------------------------------------------------------------------
`default_nettype none

module mfl_dp #(
  parameter  int MAX_FREE   = 64,
  parameter  int COORD_BITS = 16,
  localparam int CW         = $clog2(MAX_FREE + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire mfl_pkg::dp_cmd_t      cmd,
  output mfl_pkg::dp_status_t        sts,
  // request payload
  input  wire logic [1:0]            action,
  input  wire logic [COORD_BITS-1:0] used_x,
  input  wire logic [COORD_BITS-1:0] used_y,
  input  wire logic [COORD_BITS-1:0] used_width,
  input  wire logic [COORD_BITS-1:0] used_height,
  input  wire logic [5:0]            read_index,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [COORD_BITS-1:0] cfg_data,
  // response
  input  wire logic                  rsp_ready,
  output logic                       rsp_valid,
  output logic [COORD_BITS-1:0]      entry_x,
  output logic [COORD_BITS-1:0]      entry_y,
  output logic [COORD_BITS-1:0]      entry_width,
  output logic [COORD_BITS-1:0]      entry_height,
  output logic                       entry_valid,
  output logic [CW-1:0]              free_count,
  output logic                       overflow
);

  localparam int CB  = COORD_BITS;
  localparam int AW  = (MAX_FREE > 1) ? $clog2(MAX_FREE) : 1;
  localparam int PW  = CB + 1;            // stored edge position
  localparam int EXW = CB + 2;            // far edge sums
  localparam int EW  = 2 * PW + 2 * CB;   // {x, y, w, h}
  localparam int XW  = (CW > 6) ? CW : 6;
  localparam logic [CW-1:0] MAXC = CW'(MAX_FREE);

  // memories
  logic [EW-1:0] fl_mem [MAX_FREE];
  logic [EW-1:0] pc_mem [MAX_FREE];
  logic          fl_we, fl_re, pc_we, pc_re;
  logic [AW-1:0] fl_waddr, fl_raddr, pc_waddr, pc_raddr;
  logic [EW-1:0] fl_wdata, fl_rd, pc_rd, pc_wdata;

  // control registers
  logic [CW-1:0]  cnt, i, keep, np, j, jd;
  logic [1:0]     k;
  logic           over, pv, acc, rd_ok, out_valid;
  logic [1:0]     act;
  logic [MAX_FREE-1:0] mark;
  logic [CB-1:0]  root_x, root_y, root_w, root_h;

  // payload registers
  logic [CB-1:0]  u_x, u_y, u_w, u_h;
  logic [5:0]     ridx;
  logic [EW-1:0]  cur, a_ent;
  logic [EXW-1:0] a_ex, a_ey;
  logic [CB-1:0]  res_x, res_y, res_w, res_h;
  logic           res_valid;

  // split evaluation
  logic [PW-1:0]  cur_x, cur_y;
  logic [CB-1:0]  cur_w, cur_h;
  logic [EXW-1:0] fx, fy, fex, fey, ux, uy, uex, uey;
  logic [EXW-1:0] d0, d1, d2, d3;
  logic [3:0]     pc_cond;
  logic           ovl;
  logic [EW-1:0]  piece;

  // containment evaluation
  logic [PW-1:0]  a_x, a_y, b_x, b_y;
  logic [CB-1:0]  b_w, b_h;
  logic [EXW-1:0] b_ex, b_ey;
  logic           hit;

  // read request
  logic [XW-1:0]  idx_x;

  assign cur_x = cur[EW-1 -: PW];
  assign cur_y = cur[EW-PW-1 -: PW];
  assign cur_w = cur[2*CB-1 -: CB];
  assign cur_h = cur[CB-1:0];

  assign fx  = {1'b0, cur_x};
  assign fy  = {1'b0, cur_y};
  assign fex = {1'b0, cur_x} + {2'b00, cur_w};
  assign fey = {1'b0, cur_y} + {2'b00, cur_h};
  assign ux  = {2'b00, u_x};
  assign uy  = {2'b00, u_y};
  assign uex = {2'b00, u_x} + {2'b00, u_w};
  assign uey = {2'b00, u_y} + {2'b00, u_h};
  assign d0  = uy - fy;
  assign d1  = fey - uey;
  assign d2  = ux - fx;
  assign d3  = fex - uex;

  assign ovl = !((ux >= fex) || (uex <= fx) || (uy >= fey) || (uey <= fy));
  assign pc_cond[0] = (uy > fy) && (uy < fey);   // top piece
  assign pc_cond[1] = uey < fey;                 // bottom piece
  assign pc_cond[2] = (ux > fx) && (ux < fex);   // left piece
  assign pc_cond[3] = uex < fex;                 // right piece

  always_comb begin
    case (k)
      2'd0:    piece = {cur_x, cur_y, cur_w, d0[CB-1:0]};
      2'd1:    piece = {cur_x, uey[PW-1:0], cur_w, d1[CB-1:0]};
      2'd2:    piece = {cur_x, cur_y, d2[CB-1:0], cur_h};
      default: piece = {uex[PW-1:0], cur_y, d3[CB-1:0], cur_h};
    endcase
  end

  // entry i (a) is dropped if it lies inside entry j (b), keeping the first twin
  assign a_x  = a_ent[EW-1 -: PW];
  assign a_y  = a_ent[EW-PW-1 -: PW];
  assign b_x  = fl_rd[EW-1 -: PW];
  assign b_y  = fl_rd[EW-PW-1 -: PW];
  assign b_w  = fl_rd[2*CB-1 -: CB];
  assign b_h  = fl_rd[CB-1:0];
  assign b_ex = {1'b0, b_x} + {2'b00, b_w};
  assign b_ey = {1'b0, b_y} + {2'b00, b_h};
  assign hit  = (jd != i) && (a_x >= b_x) && (a_y >= b_y) && (a_ex <= b_ex) &&
                (a_ey <= b_ey) && ((a_ent != fl_rd) || (jd < i));

  assign idx_x = XW'(ridx);

  // memory port selection
  always_comb begin
    fl_we    = 1'b0;
    fl_waddr = keep[AW-1:0];
    fl_wdata = cur;
    fl_re    = 1'b0;
    fl_raddr = i[AW-1:0];
    pc_we    = 1'b0;
    pc_waddr = np[AW-1:0];
    pc_wdata = piece;
    pc_re    = 1'b0;
    pc_raddr = i[AW-1:0];
    case (cmd.op)
      mfl_pkg::OP_INIT: begin
        fl_we    = 1'b1;
        fl_waddr = '0;
        fl_wdata = {PW'(0), PW'(0), CB'(mfl_pkg::ROOT_SIZE_RESET),
                    CB'(mfl_pkg::ROOT_SIZE_RESET)};
      end
      mfl_pkg::OP_CLR: begin
        fl_we    = 1'b1;
        fl_waddr = '0;
        fl_wdata = {1'b0, root_x, 1'b0, root_y, root_w, root_h};
      end
      mfl_pkg::OP_SPL_RD, mfl_pkg::OP_PR_RDI, mfl_pkg::OP_CP_RD: fl_re = 1'b1;
      mfl_pkg::OP_SPL_KEEP: fl_we = 1'b1;
      mfl_pkg::OP_SPL_PIECE: pc_we = pc_cond[k] && (np < MAXC);
      mfl_pkg::OP_APP_RD: pc_re = 1'b1;
      mfl_pkg::OP_APP_WR: begin
        fl_we    = cnt < MAXC;
        fl_waddr = cnt[AW-1:0];
        fl_wdata = pc_rd;
      end
      mfl_pkg::OP_PR_SCAN: begin
        fl_re    = j < cnt;
        fl_raddr = j[AW-1:0];
      end
      mfl_pkg::OP_CP_WR: begin
        fl_we    = !mark[i[AW-1:0]];
        fl_wdata = fl_rd;
      end
      mfl_pkg::OP_RD_RD: begin
        fl_re    = idx_x < XW'(cnt);
        fl_raddr = idx_x[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fl_we) fl_mem[fl_waddr] <= fl_wdata;
    if (fl_re) fl_rd <= fl_mem[fl_raddr];
    if (pc_we) pc_mem[pc_waddr] <= pc_wdata;
    if (pc_re) pc_rd <= pc_mem[pc_raddr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      root_x <= '0;
      root_y <= '0;
      root_w <= CB'(mfl_pkg::ROOT_SIZE_RESET);
      root_h <= CB'(mfl_pkg::ROOT_SIZE_RESET);
    end else if (cfg_we) begin
      unique case (mfl_pkg::cfg_reg_t'(cfg_index))
        mfl_pkg::REG_ROOT_X:      root_x <= cfg_data;
        mfl_pkg::REG_ROOT_Y:      root_y <= cfg_data;
        mfl_pkg::REG_ROOT_WIDTH:  root_w <= cfg_data;
        mfl_pkg::REG_ROOT_HEIGHT: root_h <= cfg_data;
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= CW'(1);
      over      <= 1'b0;
      i         <= '0;
      keep      <= '0;
      np        <= '0;
      j         <= '0;
      jd        <= '0;
      k         <= '0;
      pv        <= 1'b0;
      acc       <= 1'b0;
      rd_ok     <= 1'b0;
      act       <= '0;
      mark      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == mfl_pkg::OP_FIN_OUT) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        mfl_pkg::OP_ACCEPT: begin
          act  <= action;
          i    <= '0;
          keep <= '0;
          np   <= '0;
        end
        mfl_pkg::OP_CLR: begin
          cnt  <= CW'(1);
          over <= 1'b0;
        end
        mfl_pkg::OP_SPL_LD: k <= '0;
        mfl_pkg::OP_SPL_KEEP: begin
          keep <= keep + CW'(1);
          i    <= i + CW'(1);
        end
        mfl_pkg::OP_SPL_PIECE: begin
          if (pc_cond[k]) begin
            if (np < MAXC) np <= np + CW'(1);
            else over <= 1'b1;
          end
          k <= k + 2'd1;
          if (k == 2'd3) i <= i + CW'(1);
        end
        mfl_pkg::OP_SPL_END: begin
          cnt <= keep;
          i   <= '0;
        end
        mfl_pkg::OP_APP_WR: begin
          if (cnt < MAXC) cnt <= cnt + CW'(1);
          else over <= 1'b1;
          i <= i + CW'(1);
        end
        mfl_pkg::OP_APP_END: i <= '0;
        mfl_pkg::OP_PR_LDI: begin
          j   <= '0;
          pv  <= 1'b0;
          acc <= 1'b0;
        end
        mfl_pkg::OP_PR_SCAN: begin
          if (j < cnt) begin
            pv <= 1'b1;
            jd <= j;
            j  <= j + CW'(1);
          end else begin
            pv <= 1'b0;
          end
          if (pv && hit) acc <= 1'b1;
        end
        mfl_pkg::OP_PR_MARK: begin
          mark[i[AW-1:0]] <= acc;
          i <= i + CW'(1);
        end
        mfl_pkg::OP_PR_END: begin
          i    <= '0;
          keep <= '0;
        end
        mfl_pkg::OP_CP_WR: begin
          if (!mark[i[AW-1:0]]) keep <= keep + CW'(1);
          i <= i + CW'(1);
        end
        mfl_pkg::OP_CP_END: cnt <= keep;
        mfl_pkg::OP_RD_RD: rd_ok <= idx_x < XW'(cnt);
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      mfl_pkg::OP_ACCEPT: begin
        u_x       <= used_x;
        u_y       <= used_y;
        u_w       <= used_width;
        u_h       <= used_height;
        ridx      <= read_index;
        res_x     <= '0;
        res_y     <= '0;
        res_w     <= '0;
        res_h     <= '0;
        res_valid <= 1'b0;
      end
      mfl_pkg::OP_SPL_LD: cur <= fl_rd;
      mfl_pkg::OP_PR_LDI: begin
        a_ent <= fl_rd;
        a_ex  <= {1'b0, fl_rd[EW-1 -: PW]} + {2'b00, fl_rd[2*CB-1 -: CB]};
        a_ey  <= {1'b0, fl_rd[EW-PW-1 -: PW]} + {2'b00, fl_rd[CB-1:0]};
      end
      mfl_pkg::OP_RD_CAP: begin
        if (rd_ok) begin
          res_x     <= b_x[CB-1:0];
          res_y     <= b_y[CB-1:0];
          res_w     <= b_w;
          res_h     <= b_h;
          res_valid <= 1'b1;
        end
      end
      mfl_pkg::OP_FIN_OUT: begin
        entry_x      <= res_x;
        entry_y      <= res_y;
        entry_width  <= res_w;
        entry_height <= res_h;
        entry_valid  <= res_valid;
        free_count   <= cnt;
        overflow     <= over;
      end
      default: ;
    endcase
  end

  assign rsp_valid      = out_valid;
  assign sts.i_ge_cnt   = i >= cnt;
  assign sts.i_ge_np    = i >= np;
  assign sts.overlap    = ovl;
  assign sts.last_piece = k == 2'd3;
  assign sts.scan_done  = (j >= cnt) && !pv;
  assign sts.out_free   = !out_valid || rsp_ready;
  assign sts.act        = act;

endmodule

`default_nettype wire

/* sim/maxrects_free_list_update_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// maxrects_free_list_update_test
// self-checking bench for the free rectangle list: a behavioral copy of the
// split, prune and compact rules predicts every response beat, which is then
// checked field by field while both channels idle and stall at random
// ----------------------------------------------------------------------------
`default_nettype none

module maxrects_free_list_update_test;

  localparam int LIST_DEPTH = 64;
  localparam logic [1:0] ACT_UNUSED = 2'd3;  // undefined action code, must be a no-op
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    int unsigned x;
    int unsigned y;
    int unsigned w;
    int unsigned h;
  } rect_t;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic        hit;
    logic [6:0]  count;
    logic        ovf;
  } rsp_beat_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  mfl_in_if  #(.COORD_BITS(16)) req_ch ();
  mfl_out_if #(.COORD_BITS(16), .COUNT_BITS(7)) rsp_ch ();

  maxrects_free_list_update #(.MAX_FREE(LIST_DEPTH), .COORD_BITS(16)) dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predicted state of the block: root registers, free list, sticky overflow
  int unsigned root_x, root_y, root_w, root_h;
  rect_t       free_rects [LIST_DEPTH];
  rect_t       new_pieces [LIST_DEPTH];
  bit          pruned     [LIST_DEPTH];
  int unsigned free_cnt;
  int unsigned piece_cnt;
  bit          dropped;

  rsp_beat_t expected_beats[$];
  int        errors = 0;

  // sender pacing
  int  burst_left = 0;
  bit  sender_gaps = 1'b1;

  // receiver pacing: random duty windows plus an occasional long hold
  int  stall_pct = 0;
  int  window_left = 0;
  int  hold_left = 0;
  bit  hold_toggle = 1'b0;
  bit  hold_seen = 1'b0;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------
  function automatic void load_root_rect();
    free_rects[0] = '{root_x, root_y, root_w, root_h};
    free_cnt = 1;
    dropped = 1'b0;
  endfunction

  function automatic void add_piece(int unsigned x, int unsigned y,
                                    int unsigned w, int unsigned h);
    if (piece_cnt < LIST_DEPTH) begin
      new_pieces[piece_cnt] = '{x, y, w, h};
      piece_cnt++;
    end else begin
      dropped = 1'b1;
    end
  endfunction

  // returns 1 when the free rectangle overlaps the used one and was split
  function automatic bit split_rect(rect_t f, rect_t u);
    int unsigned fex, fey, uex, uey;
    fex = f.x + f.w;
    fey = f.y + f.h;
    uex = u.x + u.w;
    uey = u.y + u.h;
    if (u.x >= fex || uex <= f.x || u.y >= fey || uey <= f.y) return 1'b0;
    if (u.y > f.y && u.y < fey) add_piece(f.x, f.y, f.w, u.y - f.y);
    if (uey < fey) add_piece(f.x, uey, f.w, fey - uey);
    if (u.x > f.x && u.x < fex) add_piece(f.x, f.y, u.x - f.x, f.h);
    if (uex < fex) add_piece(uex, f.y, fex - uex, f.h);
    return 1'b1;
  endfunction

  function automatic bit contained(rect_t a, rect_t b);
    return a.x >= b.x && a.y >= b.y && a.x + a.w <= b.x + b.w &&
           a.y + a.h <= b.y + b.h;
  endfunction

  function automatic bit same_rect(rect_t a, rect_t b);
    return a.x == b.x && a.y == b.y && a.w == b.w && a.h == b.h;
  endfunction

  function automatic void place_rect(rect_t u);
    int unsigned keep;
    keep = 0;
    piece_cnt = 0;
    for (int i = 0; i < free_cnt; i++) begin
      if (!split_rect(free_rects[i], u)) free_rects[keep++] = free_rects[i];
    end
    free_cnt = keep;
    for (int i = 0; i < piece_cnt; i++) begin
      if (free_cnt < LIST_DEPTH) free_rects[free_cnt++] = new_pieces[i];
      else dropped = 1'b1;
    end
    // prune contained entries; of identical twins the earliest survives
    for (int i = 0; i < free_cnt; i++) begin
      pruned[i] = 1'b0;
      for (int j = 0; j < free_cnt; j++) begin
        if (j != i && contained(free_rects[i], free_rects[j]) &&
            (!same_rect(free_rects[i], free_rects[j]) || j < i)) begin
          pruned[i] = 1'b1;
          break;
        end
      end
    end
    keep = 0;
    for (int i = 0; i < free_cnt; i++) begin
      if (!pruned[i]) free_rects[keep++] = free_rects[i];
    end
    free_cnt = keep;
  endfunction

  function automatic rsp_beat_t predict_free_list_step(logic [1:0] act,
      logic [15:0] ux, logic [15:0] uy, logic [15:0] uw, logic [15:0] uh,
      logic [5:0] idx);
    rsp_beat_t b;
    b = '{default: '0};
    if (act == mfl_pkg::ACT_PLACE) begin
      place_rect('{ux, uy, uw, uh});
    end else if (act == mfl_pkg::ACT_READ) begin
      if (idx < free_cnt) begin
        b.x = free_rects[idx].x[15:0];
        b.y = free_rects[idx].y[15:0];
        b.w = free_rects[idx].w[15:0];
        b.h = free_rects[idx].h[15:0];
        b.hit = 1'b1;
      end
    end else if (act == mfl_pkg::ACT_CLEAR) begin
      load_root_rect();
    end
    b.count = free_cnt[6:0];
    b.ovf = dropped;
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // response checking: a beat is taken at the edge after valid and ready were
  // both seen high at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    rsp_beat_t e;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: response beat with nothing expected", $time);
        errors++;
      end else begin
        e = expected_beats.pop_front();
        if (rsp_ch.entry_x !== e.x || rsp_ch.entry_y !== e.y ||
            rsp_ch.entry_width !== e.w || rsp_ch.entry_height !== e.h ||
            rsp_ch.entry_valid !== e.hit || rsp_ch.free_count !== e.count ||
            rsp_ch.overflow !== e.ovf) begin
          $display("%0t: mismatch expected x=%0d y=%0d w=%0d h=%0d valid=%0b count=%0d ovf=%0b",
                   $time, e.x, e.y, e.w, e.h, e.hit, e.count, e.ovf);
          $display("%0t:          actual x=%0d y=%0d w=%0d h=%0d valid=%0b count=%0d ovf=%0b",
                   $time, rsp_ch.entry_x, rsp_ch.entry_y, rsp_ch.entry_width,
                   rsp_ch.entry_height, rsp_ch.entry_valid, rsp_ch.free_count,
                   rsp_ch.overflow);
          errors++;
        end
      end
    end
  end

  // receiver: duty cycle picked per window, with some windows never stalling;
  // a flip of hold_toggle starts a long hold so the block backs up
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = 400;
      end
      if (window_left == 0) begin
        window_left = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      window_left--;
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // offers one beat and returns at the edge that takes it; valid stays high so
  // a following call continues a burst without a bubble
  task automatic send_item(logic [1:0] act, logic [15:0] ux, logic [15:0] uy,
                           logic [15:0] uw, logic [15:0] uh, logic [5:0] idx);
    logic rdy;
    if (sender_gaps && burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    req_ch.valid       <= 1'b1;
    req_ch.action      <= act;
    req_ch.used_x      <= ux;
    req_ch.used_y      <= uy;
    req_ch.used_width  <= uw;
    req_ch.used_height <= uh;
    req_ch.read_index  <= idx;
    do begin
      @(negedge clk);
      rdy = req_ch.ready;
      @(posedge clk);
    end while (!rdy);
    expected_beats.push_back(predict_free_list_step(act, ux, uy, uw, uh, idx));
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_place(int unsigned x, int unsigned y, int unsigned w,
                            int unsigned h);
    send_item(mfl_pkg::ACT_PLACE, x[15:0], y[15:0], w[15:0], h[15:0], 6'($urandom));
  endtask

  task automatic send_read(int unsigned idx);
    send_item(mfl_pkg::ACT_READ, 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), idx[5:0]);
  endtask

  task automatic send_clear();
    send_item(mfl_pkg::ACT_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 6'($urandom));
  endtask

  // stop offering and wait until every expected beat is back
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called while the block is idle; the caller drops the write enable
  task automatic write_root(mfl_pkg::cfg_reg_t r, logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
    case (r)
      mfl_pkg::REG_ROOT_X:      root_x = v;
      mfl_pkg::REG_ROOT_Y:      root_y = v;
      mfl_pkg::REG_ROOT_WIDTH:  root_w = v;
      mfl_pkg::REG_ROOT_HEIGHT: root_h = v;
    endcase
  endtask

  task automatic set_root(logic [15:0] x, logic [15:0] y, logic [15:0] w,
                          logic [15:0] h);
    write_root(mfl_pkg::REG_ROOT_X, x);
    write_root(mfl_pkg::REG_ROOT_Y, y);
    write_root(mfl_pkg::REG_ROOT_WIDTH, w);
    write_root(mfl_pkg::REG_ROOT_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // list right after reset: the root only, reads past the count come back empty
  task automatic test_reset_list();
    send_read(0);
    send_read(1);
    send_read(63);
  endtask

  task automatic test_unused_action();
    send_item(ACT_UNUSED, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 6'd63);
    send_read(0);
  endtask

  // one rectangle in the middle of the bin gives all four pieces
  task automatic test_basic_split();
    send_place(256, 256, 256, 256);
    for (int i = 0; i < 5; i++) send_read(i);
    send_place(1024, 0, 10, 10);       // touches the right edge only, no split
    send_place(0, 0, 16'hffff, 16'hffff);  // swallows everything
    send_clear();
  endtask

  // degenerate used rectangle strictly inside the root still splits it
  task automatic test_zero_size_place();
    send_place(100, 100, 0, 50);
    send_read(1);
    send_clear();
  endtask

  // root at the top of the coordinate range: piece edges need the extra bit
  task automatic test_wide_edges();
    drain();
    set_root(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_clear();
    send_place(16'hffff, 16'hffff, 1, 1);
    send_read(0);
    send_read(1);
    drain();
    set_root(0, 0, 0, 0);
    send_clear();
    send_place(0, 0, 0, 0);
  endtask

  // receiver holds off for a long stretch while reads keep coming, then the
  // sender waits for every beat before going on
  task automatic test_backpressure();
    drain();
    set_root(0, 0, 16'd1024, 16'd1024);
    send_clear();
    hold_toggle = !hold_toggle;
    sender_gaps = 1'b0;
    for (int i = 0; i < 10; i++) send_read($urandom_range(0, 63));
    send_place(512, 512, 64, 64);
    sender_gaps = 1'b1;
    drain();
  endtask

  // random packing inside the current root; mostly placements of modest size,
  // which build up many maximal rectangles and eventually overflow the list
  task automatic test_random_packing(int n_items, bit no_gaps);
    int unsigned sel, x, y, w, h;
    sender_gaps = !no_gaps;
    send_clear();
    for (int i = 0; i < n_items; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        x = root_x + $urandom_range(0, root_w);
        y = root_y + $urandom_range(0, root_h);
        w = $urandom_range(0, root_w / 4 + 1);
        h = $urandom_range(0, root_h / 4 + 1);
        send_place(x, y, w, h);
      end else if (sel < 57) begin
        send_place($urandom, $urandom, $urandom, $urandom);
      end else if (sel < 92) begin
        if ($urandom_range(0, 2) == 0) send_read($urandom_range(0, 63));
        else send_read($urandom_range(0, free_cnt));
      end else if (sel < 96) begin
        send_clear();
      end else begin
        send_item(ACT_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 6'($urandom));
      end
    end
    sender_gaps = 1'b1;
    drain();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = mfl_pkg::REG_ROOT_X;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.action = mfl_pkg::ACT_READ;
    req_ch.used_x = '0;
    req_ch.used_y = '0;
    req_ch.used_width = '0;
    req_ch.used_height = '0;
    req_ch.read_index = '0;
    root_x = 0;
    root_y = 0;
    root_w = mfl_pkg::ROOT_SIZE_RESET;
    root_h = mfl_pkg::ROOT_SIZE_RESET;
    load_root_rect();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_list();
    test_unused_action();
    test_basic_split();
    test_zero_size_place();
    test_wide_edges();
    test_backpressure();

    drain();
    set_root(0, 0, 16'd1024, 16'd1024);
    test_random_packing(70, 1'b0);
    drain();
    set_root(16'($urandom), 16'($urandom), 16'($urandom_range(8, 4000)),
             16'($urandom_range(8, 4000)));
    test_random_packing(60, 1'b1);
    drain();
    set_root(16'd3, 16'd5, 16'd64, 16'd48);
    test_random_packing(50, 1'b0);
    drain();
    set_root(16'hffff, 16'h0000, 16'hffff, 16'hffff);
    test_random_packing(50, 1'b0);

    drain();
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // the time limit leaves wide margin over the longest place on a full list
  initial begin
    #80_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
